// ===== design/brute_force_string_match_macros.svh =====
// ----------------------------------------------------------------------------
// brute force string match assertion macros
// shared property forms, clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BRUTE_FORCE_STRING_MATCH_MACROS_SVH
`define BRUTE_FORCE_STRING_MATCH_MACROS_SVH

// condition holds at every edge out of reset
`define BFSM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BFSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define BFSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bfsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsm_pkg
// types and constants shared by the string match controller and datapath
// ----------------------------------------------------------------------------
package bfsm_pkg;

  // result field widths
  localparam int unsigned POS_W = 8;
  localparam int unsigned CNT_W = 17;

  // comparison counter ceiling
  localparam logic [CNT_W-1:0] CMP_SAT = {CNT_W{1'b1}};

  // request codes carried in tuser
  typedef enum logic [1:0] {
    REQ_PATTERN = 2'd0,
    REQ_TEXT    = 2'd1,
    REQ_SEARCH  = 2'd2
  } req_e;

  // controller to datapath commands
  typedef struct packed {
    logic app_pat;  // write byte at end of pattern store
    logic app_txt;  // write byte at end of text store
    logic start;    // clear cursors and compare count
    logic step;     // one comparison on the registered read bytes
    logic finish;   // latch result, clear both lengths
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic stop;     // a cursor has reached the end of its string
  } sts_t;

endpackage

// ===== design/bfsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfsm_ctrl
// request decode and search sequencing for the string matcher, plus the
// output word valid flag
// ----------------------------------------------------------------------------
`include "brute_force_string_match_macros.svh"

module bfsm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_req_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bfsm_pkg::sts_t sts_i,
  output bfsm_pkg::cmd_t cmd_o
);
  import bfsm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CMP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  req_e   req;

  assign req        = req_e'(in_req_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (req)
            REQ_PATTERN: cmd_o.app_pat = 1'b1;
            REQ_TEXT:    cmd_o.app_txt = 1'b1;
            REQ_SEARCH: begin
              cmd_o.start = 1'b1;
              state_d     = S_FETCH;
            end
            default: ;
          endcase
        end
      end
      // read bytes under the cursors, or end the walk
      S_FETCH: begin
        if (sts_i.stop) begin
          state_d = S_DONE;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = S_FETCH;
      end
      // wait for the output register to be free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `BFSM_ASSERT_NEXT(a_search_blocks, in_fire && (req == REQ_SEARCH), !in_ready_o, "search did not stall input")
  `BFSM_ASSERT_SAME(a_no_overwrite, cmd_o.finish, !out_valid_q || out_ready_i, "result word overwritten")
  `BFSM_ASSERT_SAME(a_rise_after_done, $rose(out_valid_q), $past(state_q == S_DONE), "result word without search")

endmodule

// ===== design/bfsm_dp.sv =====
// ----------------------------------------------------------------------------
// bfsm_dp
// pattern and text stores, search cursors, comparison counter and result
// registers for the string matcher
// ----------------------------------------------------------------------------
`include "brute_force_string_match_macros.svh"

module bfsm_dp #(
  parameter int unsigned TEXT_MAX    = 256,
  parameter int unsigned PATTERN_MAX = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfsm_pkg::cmd_t             cmd_i,
  input  logic [7:0]                 char_i,
  output bfsm_pkg::sts_t             sts_o,
  output logic                       found_o,
  output logic [bfsm_pkg::POS_W-1:0] match_position_o,
  output logic [bfsm_pkg::CNT_W-1:0] compare_count_o
);
  import bfsm_pkg::*;

  localparam int unsigned TW  = $clog2(TEXT_MAX + 1);
  localparam int unsigned PW  = $clog2(PATTERN_MAX + 1);
  localparam int unsigned TAW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  localparam int unsigned PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned CW  = (TW > PW) ? TW : PW;

  logic [7:0] txt_mem [TEXT_MAX];
  logic [7:0] pat_mem [PATTERN_MAX];
  logic [7:0] txt_rd_q, pat_rd_q;

  logic [TW-1:0]    tlen_q, tlen_d, tc_q, tc_d;
  logic [PW-1:0]    plen_q, plen_d, pc_q, pc_d;
  logic [CNT_W-1:0] cmps_q, cmps_d;
  logic [CW-1:0]    tc_w, pc_w, back_w, start_w;
  logic [CW+7:0]    start_ext;
  logic             found;

  logic             found_q;
  logic [POS_W-1:0] pos_q;
  logic [CNT_W-1:0] cnt_q;

  // store writes and registered reads under the cursors
  always_ff @(posedge clk_i) begin
    if (cmd_i.app_txt && (tlen_q < TW'(TEXT_MAX))) begin
      txt_mem[tlen_q[TAW-1:0]] <= char_i;
    end
    txt_rd_q <= txt_mem[tc_q[TAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.app_pat && (plen_q < PW'(PATTERN_MAX))) begin
      pat_mem[plen_q[PAW-1:0]] <= char_i;
    end
    pat_rd_q <= pat_mem[pc_q[PAW-1:0]];
  end

  // cursor arithmetic in a common width
  assign tc_w      = CW'(tc_q);
  assign pc_w      = CW'(pc_q);
  assign back_w    = tc_w - pc_w + CW'(1);
  assign start_w   = tc_w - pc_w;
  assign start_ext = {8'b0, start_w};
  assign found     = (pc_q == plen_q);

  assign sts_o.stop = (tc_q >= tlen_q) || (pc_q >= plen_q);

  // lengths, cursors and compare count
  always_comb begin
    tlen_d = tlen_q;
    plen_d = plen_q;
    tc_d   = tc_q;
    pc_d   = pc_q;
    cmps_d = cmps_q;
    if (cmd_i.app_txt && (tlen_q < TW'(TEXT_MAX))) begin
      tlen_d = tlen_q + TW'(1);
    end
    if (cmd_i.app_pat && (plen_q < PW'(PATTERN_MAX))) begin
      plen_d = plen_q + PW'(1);
    end
    if (cmd_i.start) begin
      tc_d   = '0;
      pc_d   = '0;
      cmps_d = '0;
    end
    if (cmd_i.step) begin
      if (txt_rd_q == pat_rd_q) begin
        tc_d = tc_q + TW'(1);
        pc_d = pc_q + PW'(1);
      end else begin
        tc_d = back_w[TW-1:0];
        pc_d = '0;
      end
      if (cmps_q != CMP_SAT) begin
        cmps_d = cmps_q + CNT_W'(1);
      end
    end
    if (cmd_i.finish) begin
      tlen_d = '0;
      plen_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlen_q <= '0;
      plen_q <= '0;
      tc_q   <= '0;
      pc_q   <= '0;
      cmps_q <= '0;
    end else begin
      tlen_q <= tlen_d;
      plen_q <= plen_d;
      tc_q   <= tc_d;
      pc_q   <= pc_d;
      cmps_q <= cmps_d;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_q <= found;
      pos_q   <= found ? start_ext[POS_W-1:0] : '0;
      cnt_q   <= cmps_q;
    end
  end

  assign found_o          = found_q;
  assign match_position_o = pos_q;
  assign compare_count_o  = cnt_q;

  `BFSM_ASSERT_ALWAYS(a_pc_le_tc, CW'(pc_q) <= CW'(tc_q), "pattern cursor passed text cursor")
  `BFSM_ASSERT_SAME(a_step_in_range, cmd_i.step, (tc_q < tlen_q) && (pc_q < plen_q), "compare past end")
  `BFSM_ASSERT_NEXT(a_finish_clears, cmd_i.finish, (tlen_q == '0) && (plen_q == '0), "lengths not cleared")

endmodule

// ===== design/brute_force_string_match.sv =====
// throughput: one append per cycle while no search is running; a search holds tready
//   low until its result word is latched, each comparison being a registered read of
//   both stores and then a compare step, and it also waits while the previous result
//   word still waits for m_axis_tready
// reset: both lengths clear, the stores keep undefined contents until written
// ----------------------------------------------------------------------------
// brute_force_string_match
// stream block that builds a pattern and a text from appended bytes and runs
// a brute-force search on request, returning one result word per search
// ----------------------------------------------------------------------------
module brute_force_string_match #(
  parameter int unsigned TEXT_MAX    = 256,
  parameter int unsigned PATTERN_MAX = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [0] found, [8:1] match_position,
                                        // [25:9] compare_count, [31:26] zero
);
  import bfsm_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic             found;
  logic [POS_W-1:0] match_position;
  logic [CNT_W-1:0] compare_count;

  // search sequencer
  bfsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_req_i    (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // stores and matcher
  bfsm_dp #(
    .TEXT_MAX    (TEXT_MAX),
    .PATTERN_MAX (PATTERN_MAX)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .char_i           (s_axis_tdata_i),
    .sts_o            (sts),
    .found_o          (found),
    .match_position_o (match_position),
    .compare_count_o  (compare_count)
  );

  // result word packing
  assign m_axis_tdata_o = {6'b0, compare_count, match_position, found};

endmodule
